FILE: rtl/pws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pws_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int LVL_W = 8;
	localparam int IDX_W = 8;
	localparam int NCH = 3;
	localparam int RGB_W = NCH * LVL_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END = 1'b1;

	localparam logic [LVL_W-1:0] WIN_START_RST = 8'd0;
	localparam logic [LVL_W-1:0] WIN_END_RST = 8'd255;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CLS_WINDOW = 2'd0,
		CLS_LOW = 2'd1,
		CLS_HIGH = 2'd2
	} cls_t;

	typedef struct packed {
		op_t operation;
		logic [IDX_W-1:0] entry_index;
		logic [LVL_W-1:0] red_in;
		logic [LVL_W-1:0] green_in;
		logic [LVL_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] entry_out;
		logic [LVL_W-1:0] red_out;
		logic [LVL_W-1:0] green_out;
		logic [LVL_W-1:0] blue_out;
	} out_item_t;

	// sideband carried through the index divider
	typedef struct packed {
		op_t op;
		logic [IDX_W-1:0] idx;
		logic [RGB_W-1:0] rgb;
		cls_t cls;
		logic [LVL_W-1:0] d;
	} mid_t;

endpackage

`default_nettype wire

FILE: rtl/palette_window_stretch_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Windowed palette stretch.
// req channel (req_valid/req_stall/req): a transaction either writes one
// source palette entry (operation write) or queries one stretched index
// (operation query). Writes give no response; each query gives exactly one
// rsp transaction (rsp_valid/rsp_stall/rsp), in request order.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets window_start
// (index 0) and window_end (index 1); cfg_ready is always high. Change the
// window only while no query is in flight.
// Pipeline: a query passes through one setup stage, AW stages of the
// position divider (AW is log2 of the palette depth), the palette read,
// two multiply/add stages, 8 stages of the level divider and the output
// register.
// Throughput: one transaction per cycle while rsp is not stalled. The whole pipeline advances
// together; while rsp is held by rsp_stall, req_stall is raised and every
// stage keeps its contents, so nothing is dropped or repeated.
// Reset clears the window to 0..255 and all valid flags; palette contents
// are undefined until written. There is no clearing pass.
module palette_window_stretch_top #(
	parameter int PALETTE_ENTRIES = pws_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  pws_pkg::in_item_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output pws_pkg::out_item_t rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pws_pkg::LVL_W-1:0] cfg_data
);

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam int LAST = PALETTE_ENTRIES - 1;
	localparam int QPW = pws_pkg::IDX_W + AW;
	localparam int LW = pws_pkg::LVL_W;
	localparam int PW = 2 * LW;

	logic en;
	logic [LW-1:0] start_q;
	logic [LW-1:0] end_q;

	assign en = !(rsp_valid && rsp_stall);
	assign req_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= pws_pkg::WIN_START_RST;
			end_q <= pws_pkg::WIN_END_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pws_pkg::CFG_WINDOW_START: start_q <= cfg_data;
				pws_pkg::CFG_WINDOW_END: end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: classify, position numerator
	logic hi;
	logic lo;
	logic [LW-1:0] x;
	pws_pkg::mid_t mid_c;
	logic [QPW-1:0] q_c;

	always_comb begin
		hi = (req.entry_index >= end_q);
		lo = !hi && (req.entry_index < start_q);
		x = req.entry_index - start_q;
		mid_c.op = req.operation;
		mid_c.idx = req.entry_index;
		mid_c.rgb = {req.red_in, req.green_in, req.blue_in};
		if (hi) begin
			mid_c.cls = pws_pkg::CLS_HIGH;
		end else if (lo) begin
			mid_c.cls = pws_pkg::CLS_LOW;
		end else begin
			mid_c.cls = pws_pkg::CLS_WINDOW;
		end
		if (!hi && !lo) begin
			mid_c.d = end_q - start_q;
			q_c = QPW'(32'(x) * LAST);
		end else begin
			mid_c.d = LW'(1);
			q_c = '0;
		end
	end

	logic vld_s1;
	pws_pkg::mid_t mid_s1;
	logic [QPW-1:0] q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1 <= mid_c;
			q_s1 <= q_c;
		end
	end

	// position divider: n = q / d, r = q mod d
	logic d1_valid;
	logic [AW-1:0] n_d1;
	logic [LW-1:0] r_d1;
	pws_pkg::mid_t mid_d1;

	pws_div_pipe #(
		.QW(AW),
		.LANES(1),
		.SW($bits(pws_pkg::mid_t))
	) u_div_pos (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s1),
		.in_hi(q_s1[QPW-1:AW]),
		.in_lo(q_s1[AW-1:0]),
		.in_div(mid_s1.d),
		.in_side(mid_s1),
		.out_valid(d1_valid),
		.out_quo(n_d1),
		.out_rem(r_d1),
		.out_side(mid_d1)
	);

	// palette access; writes land here so they stay in order with queries
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_b;
	logic wr_ok;
	logic we;
	logic [pws_pkg::RGB_W-1:0] rd_a;
	logic [pws_pkg::RGB_W-1:0] rd_b;

	always_comb begin
		unique case (mid_d1.cls)
			pws_pkg::CLS_HIGH: addr_a = AW'(LAST);
			pws_pkg::CLS_LOW: addr_a = '0;
			default: addr_a = n_d1;
		endcase
		addr_b = addr_a + AW'(1);
		wr_ok = (32'(mid_d1.idx) < PALETTE_ENTRIES);
		we = en && d1_valid && (mid_d1.op == pws_pkg::OP_WRITE) && wr_ok;
	end

	pws_pal_mem #(
		.ENTRIES(PALETTE_ENTRIES)
	) u_mem (
		.clk(clk),
		.we(we),
		.waddr(AW'(mid_d1.idx)),
		.wdata(mid_d1.rgb),
		.en(en),
		.raddr_a(addr_a),
		.raddr_b(addr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	logic vld_s3;
	logic [pws_pkg::IDX_W-1:0] idx_s3;
	logic [LW-1:0] d_s3;
	logic [LW-1:0] r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= d1_valid && (mid_d1.op == pws_pkg::OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3 <= mid_d1.idx;
			d_s3 <= mid_d1.d;
			r_s3 <= r_d1;
		end
	end

	// stage 4: per-channel products
	logic [pws_pkg::NCH-1:0][PW-1:0] pa_c;
	logic [pws_pkg::NCH-1:0][PW-1:0] pb_c;

	always_comb begin
		logic [LW-1:0] a;
		logic [LW-1:0] b;
		logic [LW-1:0] w;
		w = d_s3 - r_s3;
		for (int c = 0; c < pws_pkg::NCH; c++) begin
			a = rd_a[pws_pkg::RGB_W-1-LW*c -: LW];
			// second entry only matters with a nonzero remainder
			b = (r_s3 != '0) ? rd_b[pws_pkg::RGB_W-1-LW*c -: LW] : '0;
			pa_c[c] = PW'(a * w);
			pb_c[c] = PW'(b * r_s3);
		end
	end

	logic vld_s4;
	logic [pws_pkg::IDX_W-1:0] idx_s4;
	logic [LW-1:0] d_s4;
	logic [pws_pkg::NCH-1:0][PW-1:0] pa_s4;
	logic [pws_pkg::NCH-1:0][PW-1:0] pb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s4 <= idx_s3;
			d_s4 <= d_s3;
			pa_s4 <= pa_c;
			pb_s4 <= pb_c;
		end
	end

	// stage 5: weighted sums, at most 255*d
	logic vld_s5;
	logic [pws_pkg::IDX_W-1:0] idx_s5;
	logic [LW-1:0] d_s5;
	logic [pws_pkg::NCH-1:0][PW-1:0] num_s5;
	logic [pws_pkg::NCH-1:0][LW-1:0] num_hi;
	logic [pws_pkg::NCH-1:0][LW-1:0] num_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s5 <= idx_s4;
			d_s5 <= d_s4;
			for (int c = 0; c < pws_pkg::NCH; c++) begin
				num_s5[c] <= pa_s4[c] + pb_s4[c];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < pws_pkg::NCH; c++) begin
			num_hi[c] = num_s5[c][PW-1:LW];
			num_lo[c] = num_s5[c][LW-1:0];
		end
	end

	// level divider: three channels share the divisor
	logic d2_valid;
	logic [pws_pkg::NCH-1:0][LW-1:0] lvl_d2;
	logic [pws_pkg::IDX_W-1:0] idx_d2;

	pws_div_pipe #(
		.QW(LW),
		.LANES(pws_pkg::NCH),
		.SW(pws_pkg::IDX_W)
	) u_div_lvl (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s5),
		.in_hi(num_hi),
		.in_lo(num_lo),
		.in_div(d_s5),
		.in_side(idx_s5),
		.out_valid(d2_valid),
		.out_quo(lvl_d2),
		.out_rem(),
		.out_side(idx_d2)
	);

	logic rsp_valid_q;
	pws_pkg::out_item_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && d2_valid) begin
			rsp_q.entry_out <= idx_d2;
			rsp_q.red_out <= lvl_d2[0];
			rsp_q.green_out <= lvl_d2[1];
			rsp_q.blue_out <= lvl_d2[2];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/pws_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. Requires in_hi < in_div.
module pws_div_pipe #(
	parameter int QW = 8,
	parameter int LANES = 1,
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [LANES-1:0][pws_pkg::LVL_W-1:0] in_hi,
	input  logic [LANES-1:0][QW-1:0] in_lo,
	input  logic [pws_pkg::LVL_W-1:0] in_div,
	input  logic [SW-1:0] in_side,
	output logic out_valid,
	output logic [LANES-1:0][QW-1:0] out_quo,
	output logic [LANES-1:0][pws_pkg::LVL_W-1:0] out_rem,
	output logic [SW-1:0] out_side
);

	logic vld_s [1:QW];
	logic [LANES-1:0][pws_pkg::LVL_W-1:0] rem_s [1:QW];
	logic [LANES-1:0][QW-1:0] lo_s [1:QW];
	logic [pws_pkg::LVL_W-1:0] div_s [1:QW];
	logic [SW-1:0] side_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic cur_vld;
		logic [LANES-1:0][pws_pkg::LVL_W-1:0] cur_rem;
		logic [LANES-1:0][QW-1:0] cur_lo;
		logic [pws_pkg::LVL_W-1:0] cur_div;
		logic [SW-1:0] cur_side;
		logic [LANES-1:0][pws_pkg::LVL_W-1:0] nxt_rem;
		logic [LANES-1:0][QW-1:0] nxt_lo;

		if (k == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_rem = in_hi;
			assign cur_lo = in_lo;
			assign cur_div = in_div;
			assign cur_side = in_side;
		end else begin : g_rest
			assign cur_vld = vld_s[k];
			assign cur_rem = rem_s[k];
			assign cur_lo = lo_s[k];
			assign cur_div = div_s[k];
			assign cur_side = side_s[k];
		end

		always_comb begin
			logic [pws_pkg::LVL_W:0] t;
			logic ge;
			for (int l = 0; l < LANES; l++) begin
				t = {cur_rem[l], cur_lo[l][QW-1]};
				ge = (t >= {1'b0, cur_div});
				nxt_rem[l] = ge ? pws_pkg::LVL_W'(t - {1'b0, cur_div})
						: t[pws_pkg::LVL_W-1:0];
				nxt_lo[l] = {cur_lo[l][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= nxt_rem;
				lo_s[k+1] <= nxt_lo;
				div_s[k+1] <= cur_div;
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quo = lo_s[QW];
	assign out_rem = rem_s[QW];
	assign out_side = side_s[QW];

endmodule

`default_nettype wire

FILE: rtl/pws_pal_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pws_pal_mem #(
	parameter int ENTRIES = pws_pkg::PALETTE_ENTRIES_DEF,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [pws_pkg::RGB_W-1:0] wdata,
	input  logic en,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [pws_pkg::RGB_W-1:0] rdata_a,
	output logic [pws_pkg::RGB_W-1:0] rdata_b
);

	logic [pws_pkg::RGB_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (en) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire
